// ----- rtl/iff_pkg.sv -----
package iff_pkg;

  localparam int MAX_FIELD_CHARS_DEF = 64;
  localparam int VALUE_BITS_DEF      = 64;

  // Digit slots: 22 octal digits cover 64 bits, 20 BCD digits cover 64 bits.
  localparam int DIG_N = 22;
  localparam int BCD_N = 20;

  typedef logic [2:0] func_t;
  localparam func_t FN_SDEC = 3'd0;
  localparam func_t FN_UDEC = 3'd1;
  localparam func_t FN_OCT  = 3'd2;
  localparam func_t FN_HEXL = 3'd3;
  localparam func_t FN_HEXU = 3'd4;

  typedef logic [1:0] size_t;
  localparam size_t SZ_NONE = 2'd0;
  localparam size_t SZ_H    = 2'd1;
  localparam size_t SZ_L    = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_XLOW  = 8'h78;
  localparam logic [7:0] CH_XUP   = 8'h58;

  // Layout of one field, handed from the front end to the character emitter.
  typedef struct packed {
    logic [DIG_N-1:0][3:0] digs;
    logic [4:0]            dcount;
    logic                  upper;
    logic                  lead;
    logic                  sign_en;
    logic                  sign_neg;
    logic [5:0]            prepad;
    logic [6:0]            zcount;
    logic                  xflag;
    logic [5:0]            postpad;
    logic [7:0]            total;
  } field_desc_t;

endpackage

// ----- rtl/iff_front.sv -----
module iff_front #(
  parameter int VALUE_BITS      = iff_pkg::VALUE_BITS_DEF,
  parameter int MAX_FIELD_CHARS = iff_pkg::MAX_FIELD_CHARS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_func,
  input  logic [63:0]          in_raw_value,
  input  logic [1:0]           in_size_mod,
  input  logic                 in_left_justify,
  input  logic                 in_force_plus,
  input  logic                 in_space_sign,
  input  logic                 in_alternate_form,
  input  logic                 in_zero_pad,
  input  logic                 in_has_dot,
  input  logic [5:0]           in_field_width,
  input  logic [5:0]           in_precision,
  output logic                 push,
  input  logic                 push_ready,
  output iff_pkg::field_desc_t desc
);

  localparam int VB   = VALUE_BITS;
  localparam int CNTW = $clog2(VALUE_BITS + 1);
  localparam int DN   = iff_pkg::DIG_N;
  localparam int BN   = iff_pkg::BCD_N;
  localparam logic [8:0] MAXC = 9'(MAX_FIELD_CHARS);

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_SCAN, F_LAY} fstate_t;

  fstate_t         st_r;
  iff_pkg::func_t  func_r;
  logic            lj_r, plus_r, sp_r, alt_r, zp_r, dot_r, neg_r, zero_r;
  logic [5:0]      fw_r, prec_r;
  logic [VB-1:0]   magk_r, sh_r;
  logic [BN*4-1:0] bcd_r;
  logic [CNTW-1:0] cnt_r;
  logic [DN-1:0][3:0] digs_r;
  logic [4:0]      ndig_r;

  // Cut and sign handling of the incoming argument.
  logic [VB-1:0] mask_c, v_c, mag_c;
  logic          sbit_c, neg_c;

  always_comb begin
    case (in_size_mod)
      iff_pkg::SZ_H: begin
        mask_c = {{(VB-16){1'b0}}, {16{1'b1}}};
        sbit_c = in_raw_value[15];
      end
      iff_pkg::SZ_L: begin
        mask_c = {VB{1'b1}};
        sbit_c = in_raw_value[VB-1];
      end
      default: begin
        mask_c = {{(VB-32){1'b0}}, {32{1'b1}}};
        sbit_c = in_raw_value[31];
      end
    endcase
    v_c   = in_raw_value[VB-1:0] & mask_c;
    neg_c = (in_func == iff_pkg::FN_SDEC) && sbit_c;
    mag_c = neg_c ? ((~v_c + {{(VB-1){1'b0}}, 1'b1}) & mask_c) : v_c;
  end

  // One double-dabble step: correct every BCD digit, then shift in one bit.
  logic [BN*4-1:0] bcd_adj, bcd_nxt;
  always_comb begin
    for (int i = 0; i < BN; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? (bcd_r[i*4 +: 4] + 4'd3)
                                                   : bcd_r[i*4 +: 4];
    end
    bcd_nxt = {bcd_adj[BN*4-2:0], sh_r[VB-1]};
  end

  // Digit slots for the conversion's base and the count of significant digits.
  logic [DN*4-1:0]    ext_c;
  logic [DN-1:0][3:0] digs_c;
  logic [4:0]         ndig_c;
  always_comb begin
    ext_c = {{(DN*4-VB){1'b0}}, magk_r};
    for (int i = 0; i < DN; i++) begin
      if (func_r == iff_pkg::FN_OCT) digs_c[i] = {1'b0, ext_c[i*3 +: 3]};
      else if (func_r == iff_pkg::FN_HEXL || func_r == iff_pkg::FN_HEXU)
        digs_c[i] = ext_c[i*4 +: 4];
      else if (i < BN) digs_c[i] = bcd_r[i*4 +: 4];
      else digs_c[i] = 4'd0;
    end
    ndig_c = 5'd0;
    for (int i = 0; i < DN; i++) begin
      if (digs_c[i] != 4'd0) ndig_c = 5'(i + 1);
    end
  end

  // Field layout.
  logic       is_s, hexb, octb, shrink, lead, sgn, pfx;
  logic [4:0] dcount;
  logic [1:0] pfx_len;
  logic [7:0] rlen, nz, nlen, need, pad, total;
  always_comb begin
    is_s    = (func_r == iff_pkg::FN_SDEC);
    hexb    = (func_r == iff_pkg::FN_HEXL) || (func_r == iff_pkg::FN_HEXU);
    octb    = (func_r == iff_pkg::FN_OCT);
    dcount  = zero_r ? ((is_s && dot_r) ? 5'd0 : 5'd1) : ndig_r;
    pfx_len = (zero_r || !alt_r) ? 2'd0 : (hexb ? 2'd2 : (octb ? 2'd1 : 2'd0));
    pfx     = (pfx_len != 2'd0);
    rlen    = 8'(dcount) + 8'(pfx_len);
    nz      = ({2'b0, prec_r} > rlen) ? ({2'b0, prec_r} - rlen) : 8'd0;
    nlen    = nz + rlen;
    shrink  = (is_s && plus_r && !zp_r) || neg_r || sp_r;
    need    = nlen + 8'(shrink);
    pad     = ({2'b0, fw_r} > need) ? ({2'b0, fw_r} - need) : 8'd0;
    lead    = sp_r && !neg_r;
    sgn     = neg_r || (is_s && plus_r);
    total   = 8'(lead) + 8'(sgn) + pad + nlen;
    if ({1'b0, total} > MAXC) total = MAXC[7:0];

    desc.digs     = digs_r;
    desc.dcount   = dcount;
    desc.upper    = (func_r == iff_pkg::FN_HEXU);
    desc.lead     = lead;
    desc.sign_en  = sgn;
    desc.sign_neg = neg_r;
    desc.prepad   = (!lj_r && !zp_r) ? pad[5:0] : 6'd0;
    desc.zcount   = (zp_r ? pad[6:0] : 7'd0) + nz[6:0] + 7'(pfx);
    desc.xflag    = (pfx_len == 2'd2);
    desc.postpad  = lj_r ? pad[5:0] : 6'd0;
    desc.total    = total;
  end

  assign in_ready = (st_r == F_IDLE);
  assign push     = (st_r == F_LAY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      case (st_r)
        F_IDLE: begin
          if (in_valid) begin
            func_r <= in_func;
            lj_r   <= in_left_justify;
            plus_r <= in_force_plus;
            sp_r   <= in_space_sign && !in_force_plus;
            alt_r  <= in_alternate_form;
            zp_r   <= in_zero_pad && !in_left_justify;
            dot_r  <= in_has_dot;
            fw_r   <= in_field_width;
            prec_r <= in_precision;
            neg_r  <= neg_c;
            magk_r <= mag_c;
            sh_r   <= mag_c;
            bcd_r  <= '0;
            cnt_r  <= '0;
            st_r   <= F_CONV;
          end
        end
        F_CONV: begin
          bcd_r <= bcd_nxt;
          sh_r  <= {sh_r[VB-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(VALUE_BITS - 1)) st_r <= F_SCAN;
        end
        F_SCAN: begin
          digs_r <= digs_c;
          ndig_r <= ndig_c;
          zero_r <= (magk_r == '0);
          st_r   <= F_LAY;
        end
        F_LAY: begin
          if (push_ready) st_r <= F_IDLE;
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/iff_queue.sv -----
module iff_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 push_ready,
  input  iff_pkg::field_desc_t desc_in,
  output logic                 q_valid,
  output iff_pkg::field_desc_t desc_out,
  input  logic                 pop
);

  iff_pkg::field_desc_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign q_valid    = (cnt_r != 2'd0);
  assign desc_out   = mem_r[rp_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= desc_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ----- rtl/iff_back.sv -----
module iff_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  iff_pkg::field_desc_t q_desc,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_char,
  output logic                 out_last_char
);

  typedef enum logic [2:0] {
    P_IDLE, P_LSP, P_PRE, P_SIGN, P_ZERO, P_X, P_DIG, P_POST
  } phase_t;

  phase_t               ph_r, ph_nxt;
  iff_pkg::field_desc_t d_r, d_nxt;
  logic [6:0]           rem_r, rem_nxt, rem_m1;
  logic [7:0]           left_r, left_nxt;
  logic                 ov_r, ov_nxt, last_r, last_nxt, emit, slot;
  logic [7:0]           ch_r, ch_nxt, ch_c;
  logic [3:0]           dig;

  assign slot   = !ov_r || out_ready;
  assign rem_m1 = rem_r - 7'd1;
  assign dig    = d_r.digs[rem_m1[4:0]];

  always_comb begin
    case (ph_r)
      P_SIGN:  ch_c = d_r.sign_neg ? iff_pkg::CH_MINUS : iff_pkg::CH_PLUS;
      P_ZERO:  ch_c = iff_pkg::CH_ZERO;
      P_X:     ch_c = d_r.upper ? iff_pkg::CH_XUP : iff_pkg::CH_XLOW;
      P_DIG: begin
        if (dig < 4'd10) ch_c = iff_pkg::CH_ZERO + 8'(dig);
        else ch_c = (d_r.upper ? 8'h37 : 8'h57) + 8'(dig);
      end
      default: ch_c = iff_pkg::CH_SPACE;
    endcase
  end

  always_comb begin
    ph_nxt   = ph_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    left_nxt = left_r;
    ch_nxt   = ch_r;
    last_nxt = last_r;
    ov_nxt   = ov_r && !out_ready;
    pop      = 1'b0;
    emit     = 1'b0;
    case (ph_r)
      P_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_desc.total != 8'd0) begin
            d_nxt    = q_desc;
            ph_nxt   = P_LSP;
            rem_nxt  = 7'(q_desc.lead);
            left_nxt = q_desc.total;
          end
        end
      end
      default: begin
        if (rem_r == 7'd0) begin
          // Segment done: move on and load the length of the next one.
          case (ph_r)
            P_LSP:  begin ph_nxt = P_PRE;  rem_nxt = 7'(d_r.prepad);  end
            P_PRE:  begin ph_nxt = P_SIGN; rem_nxt = 7'(d_r.sign_en); end
            P_SIGN: begin ph_nxt = P_ZERO; rem_nxt = d_r.zcount;      end
            P_ZERO: begin ph_nxt = P_X;    rem_nxt = 7'(d_r.xflag);   end
            P_X:    begin ph_nxt = P_DIG;  rem_nxt = 7'(d_r.dcount);  end
            P_DIG:  begin ph_nxt = P_POST; rem_nxt = 7'(d_r.postpad); end
            default: ph_nxt = P_IDLE;
          endcase
        end else if (slot) begin
          emit     = 1'b1;
          rem_nxt  = rem_m1;
          left_nxt = left_r - 8'd1;
          ov_nxt   = 1'b1;
          ch_nxt   = ch_c;
          last_nxt = (left_r == 8'd1);
          // Characters past the field limit are dropped here.
          if (left_r == 8'd1) ph_nxt = P_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= P_IDLE;
      ov_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      ov_r <= ov_nxt;
    end
    d_r    <= d_nxt;
    rem_r  <= rem_nxt;
    left_r <= left_nxt;
    ch_r   <= ch_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = ov_r;
  assign out_char      = ch_r;
  assign out_last_char = last_r;

  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r != P_IDLE |-> left_r != 8'd0)
    else $error("active field with no characters left");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    emit && left_r == 8'd1 |=> ph_r == P_IDLE && ov_r && last_r)
    else $error("last beat did not close the field");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !ov_r || out_ready)
    else $error("pending beat overwritten");

endmodule

// ----- rtl/integer_field_formatter.sv -----
// Flow: VALUE_BITS double-dabble steps, a digit scan and a layout state put an
// accepted item in the queue; the output stage then pops it and presents its
// characters segment by segment.
// Throughput: one beat per cycle within a field while out_ready holds, with segment
// steps between; the front end takes a new item only once the last is in the queue.
// Reset (synchronous, rst_n low) empties the front end, the queue and the output stage.
module integer_field_formatter #(
  parameter int MAX_FIELD_CHARS = iff_pkg::MAX_FIELD_CHARS_DEF,
  parameter int VALUE_BITS      = iff_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [63:0] in_raw_value,
  input  logic [1:0]  in_size_mod,
  input  logic        in_left_justify,
  input  logic        in_force_plus,
  input  logic        in_space_sign,
  input  logic        in_alternate_form,
  input  logic        in_zero_pad,
  input  logic        in_has_dot,
  input  logic [5:0]  in_field_width,
  input  logic [5:0]  in_precision,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_last_char
);

  iff_pkg::field_desc_t f_desc, q_desc;
  logic push, push_ready, q_valid, pop;

  iff_front #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_raw_value(in_raw_value), .in_size_mod(in_size_mod),
    .in_left_justify(in_left_justify), .in_force_plus(in_force_plus),
    .in_space_sign(in_space_sign), .in_alternate_form(in_alternate_form),
    .in_zero_pad(in_zero_pad), .in_has_dot(in_has_dot),
    .in_field_width(in_field_width), .in_precision(in_precision),
    .push(push), .push_ready(push_ready), .desc(f_desc)
  );

  iff_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_ready(push_ready), .desc_in(f_desc),
    .q_valid(q_valid), .desc_out(q_desc), .pop(pop)
  );

  iff_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_desc(q_desc), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_char(out_char), .out_last_char(out_last_char)
  );

endmodule
